@@ design/segment_intersection_classify_defines.svh @@
// ----------------------------------------------------------------------------
// Segment intersection classifier assertion macros
// Assertion wrappers for the design files; only sic_sat includes them.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_CLASSIFY_DEFINES_SVH
`define SEGMENT_INTERSECTION_CLASSIFY_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SIC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");
`define SIC_ASSERT_NORST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("assertion failed");
`else
`define SIC_ASSERT(lbl, prop)
`define SIC_ASSERT_NORST(lbl, prop)
`endif
`endif

@@ design/sic_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment intersection classifier package
// Shared constants, class codes and sideband type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sic_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int IN_W            = 16;
    localparam int OUT_W           = 48;

    typedef enum logic [2:0] {
        CLS_COLLINEAR = 3'd0,
        CLS_PARALLEL  = 3'd1,
        CLS_CROSS     = 3'd2,
        CLS_CD_ONLY   = 3'd3,
        CLS_AB_ONLY   = 3'd4,
        CLS_LINES     = 3'd5
    } line_class_t;

    localparam logic signed [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_NEG_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        line_class_t cls;
        logic        neg_x;
        logic        neg_y;
        logic        den_zero;
    } sic_side_t;
endpackage
`default_nettype wire

@@ design/sic_front.sv @@
// ----------------------------------------------------------------------------
// Segment intersection front end
// Five stages: differences, cross products, determinants, scaling products,
// numerator sums with sign split and classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sic_front import sic_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       adv,
    input  wire logic                       in_valid,
    input  wire logic [IN_W-1:0]            a_x,
    input  wire logic [IN_W-1:0]            a_y,
    input  wire logic [IN_W-1:0]            b_x,
    input  wire logic [IN_W-1:0]            b_y,
    input  wire logic [IN_W-1:0]            c_x,
    input  wire logic [IN_W-1:0]            c_y,
    input  wire logic [IN_W-1:0]            d_x,
    input  wire logic [IN_W-1:0]            d_y,
    output logic                            out_valid,
    output logic [3*COORD_WIDTH+4:0]        num_x,
    output logic [3*COORD_WIDTH+4:0]        num_y,
    output logic [2*COORD_WIDTH+1:0]        dmag,
    output sic_side_t                       side
);
    localparam int CW    = COORD_WIDTH;
    localparam int DF_W  = CW + 1;
    localparam int PR_W  = 2 * CW + 2;
    localparam int DN_W  = 2 * CW + 3;
    localparam int NUM_W = 3 * CW + 5;
    localparam int DM_W  = 2 * CW + 2;

    logic signed [CW-1:0]   ax, ay, bx, by, cx, cy, dx, dy;
    logic [4:0]             vld_reg;

    logic signed [CW-1:0]   ax1_reg, ay1_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg;
    logic signed [DF_W-1:0] acy_reg, dcx_reg, acx_reg, dcy_reg, bax1_reg, bay1_reg;
    logic signed [DF_W-1:0] bax2_reg, bay2_reg, bax3_reg, bay3_reg;
    logic signed [PR_W-1:0] pn1_reg, pn2_reg, pd1_reg, pd2_reg, pc1_reg, pc2_reg;
    logic signed [DN_W-1:0] den_reg, nab_reg, ncd_reg;
    logic signed [NUM_W-1:0] mx1_reg, mx2_reg, my1_reg, my2_reg;
    logic                   tin_reg, uin_reg, dz_reg, nz_reg, dneg_reg;
    logic [DM_W-1:0]        dm4_reg;

    logic signed [NUM_W-1:0] sx, sy;
    logic                    tin, uin;
    line_class_t             cls;

    assign ax = CW'(a_x);
    assign ay = CW'(a_y);
    assign bx = CW'(b_x);
    assign by = CW'(b_y);
    assign cx = CW'(c_x);
    assign cy = CW'(c_y);
    assign dx = CW'(d_x);
    assign dy = CW'(d_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    assign tin = den_reg > 0 ? (nab_reg >= 0 && nab_reg <= den_reg)
                             : (nab_reg <= 0 && nab_reg >= den_reg);
    assign uin = den_reg > 0 ? (ncd_reg >= 0 && ncd_reg <= den_reg)
                             : (ncd_reg <= 0 && ncd_reg >= den_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax1_reg  <= ax;
            ay1_reg  <= ay;
            acy_reg  <= DF_W'(ay) - DF_W'(cy);
            dcx_reg  <= DF_W'(dx) - DF_W'(cx);
            acx_reg  <= DF_W'(ax) - DF_W'(cx);
            dcy_reg  <= DF_W'(dy) - DF_W'(cy);
            bax1_reg <= DF_W'(bx) - DF_W'(ax);
            bay1_reg <= DF_W'(by) - DF_W'(ay);

            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            bax2_reg <= bax1_reg;
            bay2_reg <= bay1_reg;
            pn1_reg  <= PR_W'(acy_reg) * PR_W'(dcx_reg);
            pn2_reg  <= PR_W'(acx_reg) * PR_W'(dcy_reg);
            pd1_reg  <= PR_W'(bax1_reg) * PR_W'(dcy_reg);
            pd2_reg  <= PR_W'(bay1_reg) * PR_W'(dcx_reg);
            pc1_reg  <= PR_W'(acy_reg) * PR_W'(bax1_reg);
            pc2_reg  <= PR_W'(acx_reg) * PR_W'(bay1_reg);

            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            bax3_reg <= bax2_reg;
            bay3_reg <= bay2_reg;
            nab_reg  <= DN_W'(pn1_reg) - DN_W'(pn2_reg);
            den_reg  <= DN_W'(pd1_reg) - DN_W'(pd2_reg);
            ncd_reg  <= DN_W'(pc1_reg) - DN_W'(pc2_reg);

            mx1_reg  <= NUM_W'(ax3_reg) * NUM_W'(den_reg);
            mx2_reg  <= NUM_W'(nab_reg) * NUM_W'(bax3_reg);
            my1_reg  <= NUM_W'(ay3_reg) * NUM_W'(den_reg);
            my2_reg  <= NUM_W'(nab_reg) * NUM_W'(bay3_reg);
            tin_reg  <= tin;
            uin_reg  <= uin;
            dz_reg   <= den_reg == 0;
            nz_reg   <= nab_reg == 0;
            dneg_reg <= den_reg < 0;
            dm4_reg  <= den_reg < 0 ? DM_W'(-den_reg) : DM_W'(den_reg);
        end
    end

    assign sx = mx1_reg + mx2_reg;
    assign sy = my1_reg + my2_reg;

    always_comb begin
        if (dz_reg) begin
            cls = nz_reg ? CLS_COLLINEAR : CLS_PARALLEL;
        end else if (tin_reg && uin_reg) begin
            cls = CLS_CROSS;
        end else if (uin_reg) begin
            cls = CLS_CD_ONLY;
        end else if (tin_reg) begin
            cls = CLS_AB_ONLY;
        end else begin
            cls = CLS_LINES;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_x         <= sx[NUM_W-1] ? NUM_W'(-sx) : NUM_W'(sx);
            num_y         <= sy[NUM_W-1] ? NUM_W'(-sy) : NUM_W'(sy);
            dmag          <= dm4_reg;
            side.cls      <= cls;
            side.neg_x    <= sx[NUM_W-1] ^ dneg_reg;
            side.neg_y    <= sy[NUM_W-1] ^ dneg_reg;
            side.den_zero <= dz_reg;
        end
    end

    assign out_valid = vld_reg[4];
endmodule
`default_nettype wire

@@ design/sic_div.sv @@
// ----------------------------------------------------------------------------
// Segment intersection divider
// Two-lane restoring divider with a shared divisor, one quotient bit per
// pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sic_div import sic_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   adv,
    input  wire logic                                   in_valid,
    input  wire logic [3*COORD_WIDTH+4:0]               num_x,
    input  wire logic [3*COORD_WIDTH+4:0]               num_y,
    input  wire logic [2*COORD_WIDTH+1:0]               dmag,
    input  wire sic_side_t                              side_in,
    output logic                                        out_valid,
    output logic [3*COORD_WIDTH+4+FRAC_BITS:0]          quo_x,
    output logic [3*COORD_WIDTH+4+FRAC_BITS:0]          quo_y,
    output sic_side_t                                   side_out
);
    localparam int NW   = 3 * COORD_WIDTH + 5;
    localparam int DM_W = 2 * COORD_WIDTH + 2;
    localparam int QW   = NW + FRAC_BITS;

    logic [QW:0]       vld_reg;
    logic [NW-1:0]     nx_reg [QW+1];
    logic [NW-1:0]     ny_reg [QW+1];
    logic [DM_W-1:0]   rx_reg [QW+1];
    logic [DM_W-1:0]   ry_reg [QW+1];
    logic [QW-1:0]     qx_reg [QW+1];
    logic [QW-1:0]     qy_reg [QW+1];
    logic [DM_W-1:0]   dm_reg [QW+1];
    sic_side_t         sd_reg [QW+1];

    always_comb begin
        vld_reg[0] = in_valid;
        nx_reg[0]  = num_x;
        ny_reg[0]  = num_y;
        rx_reg[0]  = '0;
        ry_reg[0]  = '0;
        qx_reg[0]  = '0;
        qy_reg[0]  = '0;
        dm_reg[0]  = dmag;
        sd_reg[0]  = side_in;
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DM_W:0] tx, ty;
        logic          gx, gy;

        assign tx = {rx_reg[k], nx_reg[k][NW-1]};
        assign ty = {ry_reg[k], ny_reg[k][NW-1]};
        assign gx = tx >= {1'b0, dm_reg[k]};
        assign gy = ty >= {1'b0, dm_reg[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                nx_reg[k+1] <= nx_reg[k] << 1;
                ny_reg[k+1] <= ny_reg[k] << 1;
                rx_reg[k+1] <= gx ? DM_W'(tx - {1'b0, dm_reg[k]}) : DM_W'(tx);
                ry_reg[k+1] <= gy ? DM_W'(ty - {1'b0, dm_reg[k]}) : DM_W'(ty);
                qx_reg[k+1] <= {qx_reg[k][QW-2:0], gx};
                qy_reg[k+1] <= {qy_reg[k][QW-2:0], gy};
                dm_reg[k+1] <= dm_reg[k];
                sd_reg[k+1] <= sd_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo_x     = qx_reg[QW];
    assign quo_y     = qy_reg[QW];
    assign side_out  = sd_reg[QW];
endmodule
`default_nettype wire

@@ design/sic_sat.sv @@
// ----------------------------------------------------------------------------
// Segment intersection output stage
// Applies the sign, saturates to the output range and holds the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "segment_intersection_classify_defines.svh"
module sic_sat import sic_pkg::*; #(
    parameter int QW = 3 * COORD_WIDTH_DEF + 5 + FRAC_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic [QW-1:0]             quo_x,
    input  wire logic [QW-1:0]             quo_y,
    input  wire sic_side_t                 side,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [2:0]                     m_line_class,
    output logic signed [OUT_W-1:0]        m_cross_x,
    output logic signed [OUT_W-1:0]        m_cross_y,
    output logic                           m_clipped
);
    localparam int EW = (QW > OUT_W + 1) ? QW : OUT_W + 1;
    localparam logic [EW-1:0] POS_L = EW'(OUT_POS_MAX);
    localparam logic [EW-1:0] NEG_L = EW'(OUT_POS_MAX) + EW'(1);

    logic [EW-1:0]           ex, ey;
    logic                    cpx, cpy;
    logic signed [OUT_W-1:0] vx, vy;

    assign ex  = EW'(quo_x);
    assign ey  = EW'(quo_y);
    assign cpx = side.neg_x ? (ex > NEG_L) : (ex > POS_L);
    assign cpy = side.neg_y ? (ey > NEG_L) : (ey > POS_L);

    always_comb begin
        if (cpx) begin
            vx = side.neg_x ? OUT_NEG_MIN : OUT_POS_MAX;
        end else begin
            vx = side.neg_x ? OUT_W'(-ex) : OUT_W'(ex);
        end
        if (cpy) begin
            vy = side.neg_y ? OUT_NEG_MIN : OUT_POS_MAX;
        end else begin
            vy = side.neg_y ? OUT_W'(-ey) : OUT_W'(ey);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (adv) begin
            m_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_line_class <= side.cls;
            m_cross_x    <= side.den_zero ? '0 : vx;
            m_cross_y    <= side.den_zero ? '0 : vy;
            m_clipped    <= side.den_zero ? 1'b0 : (cpx | cpy);
        end
    end

    `SIC_ASSERT(a_zero_point, m_valid && (m_line_class == CLS_COLLINEAR || m_line_class == CLS_PARALLEL) |-> m_cross_x == '0 && m_cross_y == '0 && !m_clipped)
    `SIC_ASSERT(a_clip_limit, m_valid && m_clipped |-> m_cross_x == OUT_POS_MAX || m_cross_x == OUT_NEG_MIN || m_cross_y == OUT_POS_MAX || m_cross_y == OUT_NEG_MIN)
    `SIC_ASSERT_NORST(a_reset_empty, $past(!aresetn) |-> !m_valid)
endmodule
`default_nettype wire

@@ design/segment_intersection_classify.sv @@
// ----------------------------------------------------------------------------
// Segment intersection classifier
// Classifies two 2D segments and reports their crossing point in fixed point.
// ----------------------------------------------------------------------------
// Usage: one input beat carries the endpoints A, B of the first segment and
// C, D of the second on s_*; one result beat on m_* carries the class code,
// the crossing point with FRAC_BITS fraction bits and the saturation flag.
// Each beat passes through five front stages of products and sums, one
// stage per quotient bit in the restoring divider, and the output register.
// Throughput is one beat per cycle while the output is not stalled. All
// stages advance together; when the receiver holds m_ready low with a beat
// waiting, the pipeline freezes and s_ready drops, so nothing is lost or
// repeated. Reset clears all valid bits and empties the pipeline; payload
// is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection_classify import sic_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [IN_W-1:0]        s_a_x,
    input  wire logic [IN_W-1:0]        s_a_y,
    input  wire logic [IN_W-1:0]        s_b_x,
    input  wire logic [IN_W-1:0]        s_b_y,
    input  wire logic [IN_W-1:0]        s_c_x,
    input  wire logic [IN_W-1:0]        s_c_y,
    input  wire logic [IN_W-1:0]        s_d_x,
    input  wire logic [IN_W-1:0]        s_d_y,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [2:0]                  m_line_class,
    output logic signed [OUT_W-1:0]     m_cross_x,
    output logic signed [OUT_W-1:0]     m_cross_y,
    output logic                        m_clipped
);
    localparam int NW   = 3 * COORD_WIDTH + 5;
    localparam int DM_W = 2 * COORD_WIDTH + 2;
    localparam int QW   = NW + FRAC_BITS;

    logic            adv;
    logic            f_valid, d_valid;
    logic [NW-1:0]   f_num_x, f_num_y;
    logic [DM_W-1:0] f_dmag;
    sic_side_t       f_side, d_side;
    logic [QW-1:0]   d_quo_x, d_quo_y;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    sic_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .a_x       (s_a_x),
        .a_y       (s_a_y),
        .b_x       (s_b_x),
        .b_y       (s_b_y),
        .c_x       (s_c_x),
        .c_y       (s_c_y),
        .d_x       (s_d_x),
        .d_y       (s_d_y),
        .out_valid (f_valid),
        .num_x     (f_num_x),
        .num_y     (f_num_y),
        .dmag      (f_dmag),
        .side      (f_side)
    );

    sic_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (f_valid),
        .num_x     (f_num_x),
        .num_y     (f_num_y),
        .dmag      (f_dmag),
        .side_in   (f_side),
        .out_valid (d_valid),
        .quo_x     (d_quo_x),
        .quo_y     (d_quo_y),
        .side_out  (d_side)
    );

    sic_sat #(.QW(QW)) u_sat (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (d_valid),
        .quo_x        (d_quo_x),
        .quo_y        (d_quo_y),
        .side         (d_side),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_class (m_line_class),
        .m_cross_x    (m_cross_x),
        .m_cross_y    (m_cross_y),
        .m_clipped    (m_clipped)
    );
endmodule
`default_nettype wire

@@ sim/tb_segment_intersection_classify.sv @@
// ----------------------------------------------------------------------------
// Segment intersection classifier testbench
// Drives pairs of 2D segments through the valid/ready input channel and
// compares every result beat with a predictor that computes the class, the
// truncated fixed-point crossing point and the saturation flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_segment_intersection_classify;
    import sic_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PAIRS = 1200;

    typedef struct {
        logic [IN_W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    } seg_pair_t;

    typedef struct {
        line_class_t             cls;
        logic signed [OUT_W-1:0] px;
        logic signed [OUT_W-1:0] py;
        logic                    clip;
    } crossing_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [IN_W-1:0] s_a_x = '0, s_a_y = '0, s_b_x = '0, s_b_y = '0;
    logic [IN_W-1:0] s_c_x = '0, s_c_y = '0, s_d_x = '0, s_d_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_line_class;
    logic signed [OUT_W-1:0] m_cross_x, m_cross_y;
    logic m_clipped;

    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    int errors = 0;
    int accepted = 0;
    int cycles = 0;
    int burst_left = 8;
    int gap_left = 0;

    segment_intersection_classify DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_x(s_a_x), .s_a_y(s_a_y), .s_b_x(s_b_x), .s_b_y(s_b_y),
        .s_c_x(s_c_x), .s_c_y(s_c_y), .s_d_x(s_d_x), .s_d_y(s_d_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_line_class(m_line_class), .m_cross_x(m_cross_x),
        .m_cross_y(m_cross_y), .m_clipped(m_clipped)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [OUT_W:0] fixed_coord(longint a, longint den, longint n,
                                                   longint delta);
        logic signed [127:0] wa, wd, wn, wl, num;
        logic [127:0] mag_num, mag_den, q;
        logic neg, clip;
        logic [OUT_W-1:0] value;
        wa = a;
        wd = den;
        wn = n;
        wl = delta;
        num = wa * wd + wn * wl;
        neg = num[127] ^ wd[127];
        mag_num = num[127] ? -num : num;
        mag_den = wd[127] ? -wd : wd;
        q = (mag_num << FRAC) / mag_den;
        clip = 1'b0;
        if (neg) begin
            if (q > (128'd1 << (OUT_W - 1))) begin
                clip = 1'b1;
                q = 128'd1 << (OUT_W - 1);
            end
            value = -q[OUT_W-1:0];
        end else begin
            if (q > ((128'd1 << (OUT_W - 1)) - 1)) begin
                clip = 1'b1;
                q = (128'd1 << (OUT_W - 1)) - 1;
            end
            value = q[OUT_W-1:0];
        end
        return {clip, value};
    endfunction

    function automatic logic in_unit(longint n, longint d);
        if (d > 0) return n >= 0 && n <= d;
        return n <= 0 && n >= d;
    endfunction

    function automatic crossing_t classify_pair(seg_pair_t p);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint acy, dcx, acx, dcy, bax, bay, nab, den, ncd;
        logic [OUT_W:0] fx, fy;
        logic tin, uin;
        crossing_t r;
        ax = longint'($signed(p.ax));
        ay = longint'($signed(p.ay));
        bx = longint'($signed(p.bx));
        by = longint'($signed(p.by));
        cx = longint'($signed(p.cx));
        cy = longint'($signed(p.cy));
        dx = longint'($signed(p.dx));
        dy = longint'($signed(p.dy));
        acy = ay - cy;
        dcx = dx - cx;
        acx = ax - cx;
        dcy = dy - cy;
        bax = bx - ax;
        bay = by - ay;
        nab = acy * dcx - acx * dcy;
        den = bax * dcy - bay * dcx;
        r.px = '0;
        r.py = '0;
        r.clip = 1'b0;
        if (den == 0) begin
            r.cls = (nab == 0) ? CLS_COLLINEAR : CLS_PARALLEL;
            return r;
        end
        ncd = acy * bax - acx * bay;
        fx = fixed_coord(ax, den, nab, bax);
        fy = fixed_coord(ay, den, nab, bay);
        r.px = fx[OUT_W-1:0];
        r.py = fy[OUT_W-1:0];
        r.clip = fx[OUT_W] | fy[OUT_W];
        tin = in_unit(nab, den);
        uin = in_unit(ncd, den);
        if (tin && uin) r.cls = CLS_CROSS;
        else if (uin) r.cls = CLS_CD_ONLY;
        else if (tin) r.cls = CLS_AB_ONLY;
        else r.cls = CLS_LINES;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
        errors++;
    endtask

    task automatic add_pair(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy);
        seg_pair_t p;
        p.ax = IN_W'(ax);
        p.ay = IN_W'(ay);
        p.bx = IN_W'(bx);
        p.by = IN_W'(by);
        p.cx = IN_W'(cx);
        p.cy = IN_W'(cy);
        p.dx = IN_W'(dx);
        p.dy = IN_W'(dy);
        pending_pairs.push_back(p);
    endtask

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    task automatic add_random_pair();
        int ax, ay, vx, vy, cx, cy, k;
        case ($urandom_range(9, 0))
            0, 1, 2, 3: begin
                add_pair($urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            end
            4: begin
                add_pair(pick(-8, 8), pick(-8, 8), pick(-8, 8), pick(-8, 8),
                         pick(-8, 8), pick(-8, 8), pick(-8, 8), pick(-8, 8));
            end
            5, 6: begin
                add_pair(pick(-1000, 1000), pick(-1000, 1000), pick(-1000, 1000),
                         pick(-1000, 1000), pick(-1000, 1000), pick(-1000, 1000),
                         pick(-1000, 1000), pick(-1000, 1000));
            end
            7: begin
                ax = pick(-16000, 16000);
                ay = pick(-16000, 16000);
                vx = pick(-16000, 16000);
                vy = pick(-16000, 16000);
                cx = ax + pick(-20, 20);
                cy = ay + pick(-20, 20);
                add_pair(ax, ay, ax + vx, ay + vy, cx, cy,
                         cx + vx + pick(-1, 1), cy + vy + pick(-1, 1));
            end
            8: begin
                ax = pick(-1000, 1000);
                ay = pick(-1000, 1000);
                vx = pick(-100, 100);
                vy = pick(-100, 100);
                k = pick(-5, 5);
                add_pair(ax, ay, ax + vx * pick(-5, 5), ay + vy * pick(-5, 5) * 0 + vy * k,
                         ax + vx * k, ay + vy * k, ax + vx * pick(-5, 5) , ay);
                if ($urandom_range(1, 0)) begin
                    k = pick(-5, 5);
                    add_pair(ax, ay, ax + vx * 3, ay + vy * 3, ax + vx * k, ay + vy * k,
                             ax + vx * (k + pick(-4, 4)), ay + vy * (k + pick(-4, 4)));
                end else begin
                    add_pair(ax, ay, ax + vx * 3, ay + vy * 3, ax + vx * 2, ay + vy * 2,
                             ax - vx, ay - vy);
                end
            end
            default: begin
                ax = pick(-3000, 3000);
                ay = pick(-3000, 3000);
                vx = pick(-3000, 3000);
                vy = pick(-3000, 3000);
                if ($urandom_range(1, 0))
                    add_pair(ax, ay, vx, vy, vx, vy, pick(-3000, 3000), pick(-3000, 3000));
                else
                    add_pair(ax, ay, vx, vy, pick(-3000, 3000), pick(-3000, 3000), ax, ay);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_segment_intersection_classify NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_crossings.push_back(classify_pair('{s_a_x, s_a_y, s_b_x, s_b_y,
                                                            s_c_x, s_c_y, s_d_x, s_d_y}));
                accepted <= accepted + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    seg_pair_t p;
                    p = pending_pairs.pop_front();
                    s_a_x <= p.ax;
                    s_a_y <= p.ay;
                    s_b_x <= p.bx;
                    s_b_y <= p.by;
                    s_c_x <= p.cx;
                    s_c_y <= p.cy;
                    s_d_x <= p.dx;
                    s_d_y <= p.dy;
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= pick(1, 40);
                        gap_left <= ($urandom_range(3, 0) == 0) ? 0 : pick(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        crossing_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if ((cycles % 600) < 150) m_ready <= 1'b1;
            else if ((cycles % 600) < 400) m_ready <= ($urandom_range(9, 0) < 7);
            else m_ready <= ($urandom_range(9, 0) < 3);
            if (m_valid && m_ready) begin
                if (expected_crossings.size() == 0) begin
                    report_mismatch("unexpected beat, class", m_line_class, -1);
                end else begin
                    want = expected_crossings.pop_front();
                    if (m_line_class !== want.cls)
                        report_mismatch("line_class", m_line_class, want.cls);
                    if (m_cross_x !== want.px)
                        report_mismatch("cross_x", m_cross_x, want.px);
                    if (m_cross_y !== want.py)
                        report_mismatch("cross_y", m_cross_y, want.py);
                    if (m_clipped !== want.clip)
                        report_mismatch("clipped", m_clipped, want.clip);
                end
            end
        end
    end

    initial begin
        int directed;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        add_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
        add_pair(0, 0, 10, 0, 0, 5, 10, 5);
        add_pair(0, 0, 10, 0, 5, 0, 20, 0);
        add_pair(0, 0, 1, 1, 5, 0, 5, 10);
        add_pair(5, 0, 5, 10, 0, 0, 1, 1);
        add_pair(0, 0, 1, 1, 5, 0, 5, 1);
        add_pair(0, 0, 10, 10, 0, 10, 10, 0);
        add_pair(0, 0, 10, 0, 0, -5, 0, 5);
        add_pair(0, 0, 10, 0, 10, -5, 10, 5);
        add_pair(0, 0, 10, 0, 3, 0, 3, 7);
        add_pair(0, 0, 32767, 1, 0, 10, 32766, 11);
        add_pair(0, 0, 32767, 1, 0, -10, 32766, -9);
        add_pair(0, 0, 1, 32767, 10, 0, 11, 32766);
        add_pair(3, 4, 3, 4, 0, 0, 10, 7);
        add_pair(0, 0, 7, 3, 2, 2, 2, 2);
        add_pair(-1, -1, 2, 3, 7, -2, -4, 9);
        add_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
        directed = pending_pairs.size();
        while (accepted < directed || expected_crossings.size() > 0) @(posedge aclk);
        for (int i = 0; i < RANDOM_PAIRS; i++) add_random_pair();
        directed = directed + pending_pairs.size();
        while (accepted < directed || expected_crossings.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_segment_intersection_classify OK");
        end else begin
            $display("tb_segment_intersection_classify NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+design
design/sic_pkg.sv
design/sic_front.sv
design/sic_div.sv
design/sic_sat.sv
design/segment_intersection_classify.sv
sim/tb_segment_intersection_classify.sv
